// ===== rtl/core/pmt_pkg.sv =====
`default_nettype none

package pmt_pkg;

    // Request codes carried in the low bits of the input word
    localparam logic [1:0] ACT_MAP   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_UNMAP = 2'd2;

    localparam int ACT_W      = 2;
    localparam int ADDR_W     = 64;
    localparam int FLAGS_W    = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int CANON_LSB  = 48;
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;

    // Present bit ORed into every stored flags word
    localparam logic [FLAGS_W-1:0] PRESENT_MASK = 64'h0000_0000_0000_0001;

    // Stream word widths, padded to whole bytes
    localparam int IN_RAW_W  = ACT_W + 2 * ADDR_W + FLAGS_W;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = 1 + ADDR_W + FLAGS_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;      // clearing pass writes one valid bit
        logic load;     // capture a new request and restart the scan
        logic scan;     // issue the next table read
        logic finish;   // latch the result and update the table
        logic push;     // move the result into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // clearing pass at the last entry
        logic pre_ok;    // request passed its address checks
        logic scan_end;  // hit found or last entry checked
        logic out_free;  // output register can take a word
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/page_mapping_table_core.sv =====
// Operation: a request is captured on acceptance and the table memories are scanned in entry order until
// a hit or the last entry; the scan reads one entry per cycle, then the result is latched and pushed out.
// Address-check failures and unknown codes skip the scan.
// Requests: one at a time; input ready returns in the cycle after the result is pushed into the output
// register, and the push waits while the output register is still full.
// Reset: synchronous, active low; a clearing pass over every entry empties the valid memory.
`default_nettype none

module page_mapping_table_core #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // action[1:0], virt_addr[65:2], phys_addr[129:66], flags_in[193:130], zero pad
    input  wire [pmt_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // ok[0], phys_found[64:1], flags_found[128:65], zero pad
    output logic [pmt_pkg::OUT_W-1:0]  m_axis_tdata
);

    pmt_pkg::t_cmd cmd;
    pmt_pkg::t_sts sts;

    pmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pmt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/pmt_datapath.sv =====
`default_nettype none

module pmt_datapath #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire pmt_pkg::t_cmd          i_cmd,
    output pmt_pkg::t_sts               o_sts,
    input  wire [pmt_pkg::IN_W-1:0]     i_in_data,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic [pmt_pkg::OUT_W-1:0]   o_out_data
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
    localparam int PW = pmt_pkg::PAGE_W;
    localparam int FW = pmt_pkg::FLAGS_W;
    localparam int XW = pmt_pkg::ADDR_W;

    // Unpack the input word
    logic [pmt_pkg::ACT_W-1:0] in_act;
    logic [XW-1:0]             in_virt;
    logic [XW-1:0]             in_phys;
    logic [FW-1:0]             in_flags;
    logic                      virt_canon;
    logic                      virt_align;
    logic                      phys_align;
    logic                      in_pre_ok;

    assign in_act   = i_in_data[pmt_pkg::ACT_W-1:0];
    assign in_virt  = i_in_data[pmt_pkg::ACT_W +: XW];
    assign in_phys  = i_in_data[pmt_pkg::ACT_W + XW +: XW];
    assign in_flags = i_in_data[pmt_pkg::ACT_W + 2 * XW +: FW];

    assign virt_canon = (in_virt[XW-1:pmt_pkg::CANON_LSB] == '0) ||
                        (in_virt[XW-1:pmt_pkg::CANON_LSB] == '1);
    assign virt_align = (in_virt[pmt_pkg::PAGE_SHIFT-1:0] == '0);
    assign phys_align = (in_phys[pmt_pkg::PAGE_SHIFT-1:0] == '0);

    // Address checks that decide whether a scan is needed at all
    always_comb begin
        unique case (in_act)
            pmt_pkg::ACT_MAP:   in_pre_ok = virt_canon && virt_align && phys_align;
            pmt_pkg::ACT_QUERY: in_pre_ok = virt_align;
            pmt_pkg::ACT_UNMAP: in_pre_ok = virt_align;
            default:            in_pre_ok = 1'b0;
        endcase
    end

    // Request registers
    logic [pmt_pkg::ACT_W-1:0] r_req_act;
    logic [PW-1:0]             r_req_vpage;
    logic [PW-1:0]             r_req_ppage;
    logic [FW-1:0]             r_req_flags;
    logic                      r_req_pre_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_act    <= in_act;
            r_req_vpage  <= in_virt[XW-1:pmt_pkg::PAGE_SHIFT];
            r_req_ppage  <= in_phys[XW-1:pmt_pkg::PAGE_SHIFT];
            r_req_flags  <= in_flags | pmt_pkg::PRESENT_MASK;
            r_req_pre_ok <= in_pre_ok;
        end
    end

    // Clearing pass counter
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Scan read address and check stage
    logic [AW-1:0] r_rd_addr;
    logic          r_rd_done;
    logic          r_chk_vld;
    logic [AW-1:0] r_chk_idx;
    logic          rd_issue;

    assign rd_issue = i_cmd.scan && !r_rd_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_rd_done <= 1'b0;
            r_chk_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_rd_addr <= '0;
            r_rd_done <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= rd_issue;
            if (rd_issue) begin
                if (r_rd_addr == LAST_IDX) begin
                    r_rd_done <= 1'b1;
                end else begin
                    r_rd_addr <= r_rd_addr + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_rd_addr;
    end

    // Table memories
    logic          mem_valid [TABLE_ENTRIES];
    logic [PW-1:0] mem_vpage [TABLE_ENTRIES];
    logic [PW-1:0] mem_ppage [TABLE_ENTRIES];
    logic [FW-1:0] mem_flags [TABLE_ENTRIES];

    logic          r_rd_valid;
    logic [PW-1:0] r_rd_vpage;
    logic [PW-1:0] r_rd_ppage;
    logic [FW-1:0] r_rd_flags;

    logic          hit;
    logic          res_ok;
    logic          map_wr;
    logic          vld_we;
    logic [AW-1:0] vld_waddr;
    logic          vld_wdata;

    // Map takes the first free entry, lookups the first valid match
    always_comb begin
        if (r_req_act == pmt_pkg::ACT_MAP) begin
            hit = r_chk_vld && !r_rd_valid;
        end else begin
            hit = r_chk_vld && r_rd_valid && (r_rd_vpage == r_req_vpage);
        end
    end

    assign res_ok = r_req_pre_ok && hit;
    assign map_wr = i_cmd.finish && res_ok && (r_req_act == pmt_pkg::ACT_MAP);

    // Valid write port: clearing pass, map sets, unmap clears
    always_comb begin
        vld_we    = 1'b0;
        vld_waddr = r_chk_idx;
        vld_wdata = 1'b0;
        if (i_cmd.clr) begin
            vld_we    = 1'b1;
            vld_waddr = r_clr_addr;
        end else if (i_cmd.finish && res_ok) begin
            if (r_req_act == pmt_pkg::ACT_MAP) begin
                vld_we    = 1'b1;
                vld_wdata = 1'b1;
            end else if (r_req_act == pmt_pkg::ACT_UNMAP) begin
                vld_we    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            mem_valid[vld_waddr] <= vld_wdata;
        end
        r_rd_valid <= mem_valid[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (map_wr) begin
            mem_vpage[r_chk_idx] <= r_req_vpage;
            mem_ppage[r_chk_idx] <= r_req_ppage;
            mem_flags[r_chk_idx] <= r_req_flags;
        end
        r_rd_vpage <= mem_vpage[r_rd_addr];
        r_rd_ppage <= mem_ppage[r_rd_addr];
        r_rd_flags <= mem_flags[r_rd_addr];
    end

    // Result registers
    logic          r_res_ok;
    logic [XW-1:0] r_res_pf;
    logic [FW-1:0] r_res_ff;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_ok <= res_ok;
            if (res_ok && (r_req_act == pmt_pkg::ACT_QUERY)) begin
                r_res_pf <= {r_rd_ppage, {pmt_pkg::PAGE_SHIFT{1'b0}}};
                r_res_ff <= r_rd_flags;
            end else begin
                r_res_pf <= '0;
                r_res_ff <= '0;
            end
        end
    end

    // Output register
    logic                     r_out_vld;
    logic [pmt_pkg::OUT_W-1:0] r_out_data;
    logic                     out_free;

    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_data <= {(pmt_pkg::OUT_W - pmt_pkg::OUT_RAW_W)'(0),
                           r_res_ff, r_res_pf, r_res_ok};
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // Status back to the controller
    always_comb begin
        o_sts.clr_last = (r_clr_addr == LAST_IDX);
        o_sts.pre_ok   = r_req_pre_ok;
        o_sts.scan_end = hit || (r_chk_vld && (r_chk_idx == LAST_IDX));
        o_sts.out_free = out_free;
    end

`ifndef SYNTHESIS
    a_push_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> r_out_vld)
        else $error("result push did not raise output valid");

    a_reject_no_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_req_pre_ok) |=> !r_res_ok)
        else $error("request failing address checks reported success");

    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_data[0]) |-> (r_out_data[pmt_pkg::OUT_RAW_W-1:1] == '0))
        else $error("failed result carries nonzero address or flags");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pmt_ctrl.sv =====
`default_nettype none

module pmt_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire pmt_pkg::t_sts  i_sts,
    output pmt_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } t_state;

    t_state r_state;
    logic   r_in_rdy;
    logic   accept;

    assign accept = i_in_valid && r_in_rdy;

    // Commands decoded from the current state, the status and the input handshake
    always_comb begin
        o_cmd.clr    = (r_state == ST_CLEAR);
        o_cmd.load   = accept;
        o_cmd.scan   = (r_state == ST_SCAN);
        o_cmd.finish = (r_state == ST_SCAN) && (!i_sts.pre_ok || i_sts.scan_end);
        o_cmd.push   = (r_state == ST_PUSH) && i_sts.out_free;
    end

    // State and input ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_in_rdy <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state  <= ST_IDLE;
                        r_in_rdy <= 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_state  <= ST_SCAN;
                        r_in_rdy <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (o_cmd.finish) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (i_sts.out_free) begin
                        r_state  <= ST_IDLE;
                        r_in_rdy <= 1'b1;
                    end
                end
                default: begin
                    r_state  <= ST_CLEAR;
                    r_in_rdy <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready = r_in_rdy;

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_SCAN) && !r_in_rdy)
        else $error("accepted word did not start a scan");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_rdy |-> (r_state == ST_IDLE))
        else $error("input ready outside idle state");

    a_push_reopens_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && i_sts.out_free) |=> r_in_rdy)
        else $error("input not reopened after result push");
`endif

endmodule

`default_nettype wire
